// File: design/sas_pkg.sv
// ----------------------------------------------------------------------------
// sas_pkg
// Shared constants, codes, types and helpers for the snapshot array store.
// ----------------------------------------------------------------------------
package sas_pkg;

  localparam int MAX_LENGTH    = 256;
  localparam int MAX_SNAPSHOTS = 16;

  localparam int DATA_W      = 32;
  localparam int LEN_W       = 9;                          // array_length register
  localparam int IDX_W       = $clog2(MAX_LENGTH);         // entry address
  localparam int SLOT_W      = $clog2(MAX_SNAPSHOTS);      // saved slot address
  localparam int LEN_CW      = $clog2(MAX_LENGTH + 1);     // copy counter, holds MAX_LENGTH
  localparam int SNAP_CW     = $clog2(MAX_SNAPSHOTS + 1);  // snapshots taken, holds MAX
  localparam int SAVED_DEPTH = MAX_SNAPSHOTS * MAX_LENGTH;
  localparam int SAVED_AW    = SLOT_W + IDX_W;

  // command codes
  localparam logic [1:0] CMD_SET  = 2'd0;
  localparam logic [1:0] CMD_SNAP = 2'd1;
  localparam logic [1:0] CMD_GET  = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  // register map (word index)
  localparam logic REG_ARRAY_LENGTH = 1'b0;

  // working copy port
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } wrk_port_t;

  // saved snapshot port
  typedef struct packed {
    logic                we;
    logic [SAVED_AW-1:0] waddr;
    logic [DATA_W-1:0]   wdata;
    logic                re;
    logic [SAVED_AW-1:0] raddr;
  } snp_port_t;

  function automatic logic index_ok(logic [7:0] idx, logic [LEN_W-1:0] len);
    return ({1'b0, idx} < len) && (int'(idx) < MAX_LENGTH);
  endfunction

endpackage

// File: design/sas_ram.sv
// ----------------------------------------------------------------------------
// sas_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sas_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/sas_apb.sv
// ----------------------------------------------------------------------------
// sas_apb
// APB register slave holding array_length.
// ----------------------------------------------------------------------------
module sas_apb (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output logic [sas_pkg::LEN_W-1:0] array_length
);

  logic wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr[2] == sas_pkg::REG_ARRAY_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      array_length <= '0;
    end else if (wr_hit) begin
      array_length <= pwdata[sas_pkg::LEN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == sas_pkg::REG_ARRAY_LENGTH) begin
      prdata = {{(32 - sas_pkg::LEN_W){1'b0}}, array_length};
    end
  end

endmodule

// File: design/sas_core.sv
// ----------------------------------------------------------------------------
// sas_core
// Command sequencer: set, get and snapshot copy over the two RAMs.
// ----------------------------------------------------------------------------
module sas_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 cmd,
  input  logic [7:0]                 index,
  input  logic signed [31:0]         write_value,
  input  logic [3:0]                 snap_id,
  input  logic [sas_pkg::LEN_W-1:0]  array_length,
  output sas_pkg::wrk_port_t         wrk,
  input  logic [sas_pkg::DATA_W-1:0] wrk_rdata,
  output sas_pkg::snp_port_t         snp,
  input  logic [sas_pkg::DATA_W-1:0] snp_rdata,
  output logic                       done,
  output logic signed [31:0]         read_value,
  output logic [3:0]                 taken_snap_id,
  output logic [1:0]                 status
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_ACCESS = 3'b010,
    S_COPY   = 3'b100
  } state_t;

  state_t                        state;
  logic [sas_pkg::LEN_CW-1:0]    rd_cnt;
  logic                          pend;
  logic [sas_pkg::IDX_W-1:0]     pend_addr;
  logic [sas_pkg::SNAP_CW-1:0]   taken;
  logic [sas_pkg::MAX_LENGTH-1:0] wvalid;

  logic                          accept;
  logic                          idx_ok;
  logic                          get_ok;
  logic                          full;
  logic                          copy_last;
  logic [sas_pkg::SLOT_W-1:0]    slot;

  always_comb begin
    busy      = (state != S_IDLE);
    accept    = start && (state == S_IDLE);
    idx_ok    = sas_pkg::index_ok(index, array_length);
    get_ok    = (sas_pkg::SNAP_CW'(snap_id) < taken)
                && (int'(snap_id) < sas_pkg::MAX_SNAPSHOTS) && idx_ok;
    full      = (taken == sas_pkg::SNAP_CW'(sas_pkg::MAX_SNAPSHOTS));
    slot      = taken[sas_pkg::SLOT_W-1:0];
    copy_last = (state == S_COPY) && (rd_cnt == sas_pkg::LEN_CW'(sas_pkg::MAX_LENGTH));

    wrk.we    = accept && (cmd == sas_pkg::CMD_SET) && idx_ok;
    wrk.waddr = index[sas_pkg::IDX_W-1:0];
    wrk.wdata = write_value;
    wrk.re    = (state == S_COPY) && (rd_cnt < sas_pkg::LEN_CW'(sas_pkg::MAX_LENGTH));
    wrk.raddr = rd_cnt[sas_pkg::IDX_W-1:0];

    // never-set entries of the working copy read as zero
    snp.we    = pend;
    snp.waddr = {slot, pend_addr};
    snp.wdata = wvalid[pend_addr] ? wrk_rdata : '0;
    snp.re    = accept && (cmd == sas_pkg::CMD_GET) && get_ok;
    snp.raddr = {snap_id[sas_pkg::SLOT_W-1:0], index[sas_pkg::IDX_W-1:0]};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      rd_cnt <= '0;
      pend   <= 1'b0;
      taken  <= '0;
      wvalid <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      pend <= wrk.re;
      case (state)
        S_IDLE: begin
          if (start) begin
            case (cmd)
              sas_pkg::CMD_SET: begin
                if (idx_ok) begin
                  wvalid[index[sas_pkg::IDX_W-1:0]] <= 1'b1;
                end
                done <= 1'b1;
              end
              sas_pkg::CMD_SNAP: begin
                if (full) begin
                  done <= 1'b1;
                end else begin
                  state  <= S_COPY;
                  rd_cnt <= '0;
                end
              end
              sas_pkg::CMD_GET: begin
                if (get_ok) begin
                  state <= S_ACCESS;
                end else begin
                  done <= 1'b1;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_ACCESS: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_COPY: begin
          if (wrk.re) begin
            rd_cnt <= rd_cnt + 1'b1;
          end
          if (copy_last) begin
            done  <= 1'b1;
            taken <= taken + 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    pend_addr <= wrk.raddr;
    case (state)
      S_IDLE: begin
        if (start) begin
          read_value    <= (cmd == sas_pkg::CMD_GET) ? '1 : '0;
          taken_snap_id <= '0;
          case (cmd)
            sas_pkg::CMD_SET:  status <= idx_ok ? sas_pkg::ST_OK : sas_pkg::ST_INVALID;
            sas_pkg::CMD_SNAP: status <= full ? sas_pkg::ST_FULL : sas_pkg::ST_OK;
            default:           status <= sas_pkg::ST_INVALID;
          endcase
        end
      end
      S_ACCESS: begin
        read_value    <= snp_rdata;
        taken_snap_id <= '0;
        status        <= sas_pkg::ST_OK;
      end
      S_COPY: begin
        if (copy_last) begin
          read_value    <= '0;
          taken_snap_id <= 4'(slot);
          status        <= sas_pkg::ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  // saved RAM is never written and read in the same cycle
  a_snp_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(snp.we && snp.re))
    else $error("saved RAM read during copy");

  // a valid get is accepted, passes through S_ACCESS and then raises done
  a_get_latency: assert property (@(posedge clk) disable iff (rst)
    snp.re |=> (state == S_ACCESS) ##1 done)
    else $error("get result late");

  // snapshot count never passes the slot count
  a_taken_bound: assert property (@(posedge clk) disable iff (rst)
    taken <= sas_pkg::SNAP_CW'(sas_pkg::MAX_SNAPSHOTS))
    else $error("snapshot count overflow");

  // end of a copy gives an ok result with the slot just filled
  a_copy_result: assert property (@(posedge clk) disable iff (rst)
    copy_last |=> done && (status == sas_pkg::ST_OK)
                  && (taken_snap_id == 4'($past(slot))))
    else $error("snapshot result wrong");

endmodule

// File: design/snapshot_array_store.sv
// ----------------------------------------------------------------------------
// snapshot_array_store
// Versioned array store: working copy, saved snapshots, set/snapshot/get.
// ----------------------------------------------------------------------------
//
//  channel   | handshake                        | payload
//  ----------+----------------------------------+------------------------------------
//  command   | start, busy (accept: start&!busy)| cmd, index, write_value, snap_id
//  result    | done (one-cycle strobe)          | read_value, taken_snap_id, status
//  config    | psel, penable, pwrite, pready    | paddr, pwdata, prdata
//
//  Flow: a set, a rejected command or a full-store snapshot gives its word in the cycle
//  after acceptance and busy stays low, so the next command can go in right away.
//  A valid get passes through S_ACCESS for the registered read of the saved-snapshot RAM.
//  A snapshot reads the working copy one entry a cycle and streams it into the slot.
//  Reset clears the length, the snapshot count and the working copy valid bits, so no
//  clearing pass; the result side has no stall.
//
module snapshot_array_store (
  input  logic               clk,
  input  logic               rst,
  // command word
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd,
  input  logic [7:0]         index,
  input  logic signed [31:0] write_value,
  input  logic [3:0]         snap_id,
  // result word
  output logic               done,
  output logic signed [31:0] read_value,
  output logic [3:0]         taken_snap_id,
  output logic [1:0]         status,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [sas_pkg::LEN_W-1:0]  array_length;
  sas_pkg::wrk_port_t         wrk;
  sas_pkg::snp_port_t         snp;
  logic [sas_pkg::DATA_W-1:0] wrk_rdata;
  logic [sas_pkg::DATA_W-1:0] snp_rdata;

  // length register
  sas_apb u_apb (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .array_length (array_length)
  );

  // working copy: written by set, read by the snapshot copy
  sas_ram #(
    .WIDTH (sas_pkg::DATA_W),
    .DEPTH (sas_pkg::MAX_LENGTH)
  ) u_wrk_ram (
    .clk   (clk),
    .we    (wrk.we),
    .waddr (wrk.waddr),
    .wdata (wrk.wdata),
    .re    (wrk.re),
    .raddr (wrk.raddr),
    .rdata (wrk_rdata)
  );

  // saved snapshots: slot in the high address bits, entry in the low bits
  sas_ram #(
    .WIDTH (sas_pkg::DATA_W),
    .DEPTH (sas_pkg::SAVED_DEPTH)
  ) u_snp_ram (
    .clk   (clk),
    .we    (snp.we),
    .waddr (snp.waddr),
    .wdata (snp.wdata),
    .re    (snp.re),
    .raddr (snp.raddr),
    .rdata (snp_rdata)
  );

  // sequencer
  sas_core u_core (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .index         (index),
    .write_value   (write_value),
    .snap_id       (snap_id),
    .array_length  (array_length),
    .wrk           (wrk),
    .wrk_rdata     (wrk_rdata),
    .snp           (snp),
    .snp_rdata     (snp_rdata),
    .done          (done),
    .read_value    (read_value),
    .taken_snap_id (taken_snap_id),
    .status        (status)
  );

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: snapshot array store testbench
// Drives set, snapshot and get command words through the start/busy port.
// Writes the length register over APB while the block is idle. A built-in
// predictor of the working copy and the saved slots gives the expected
// result word for each accepted command. A checker compares every done
// strobe with the oldest expected word.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;  // no operation, rejected
  localparam int         CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic signed [31:0] value;
    logic [3:0]         snap;
    logic [1:0]         st;
  } result_word_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         cmd = sas_pkg::CMD_SET;
  logic [7:0]         index = '0;
  logic signed [31:0] write_value = '0;
  logic [3:0]         snap_id = '0;
  logic               done;
  logic signed [31:0] read_value;
  logic [3:0]         taken_snap_id;
  logic [1:0]         status;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  // predictor state: mirrors the block's arrays, count and length register
  logic signed [31:0]          working_mirror [sas_pkg::MAX_LENGTH];
  logic signed [31:0]          saved_mirror [sas_pkg::MAX_SNAPSHOTS][sas_pkg::MAX_LENGTH];
  logic [sas_pkg::SNAP_CW-1:0] slots_used = '0;
  logic [sas_pkg::LEN_W-1:0]   length_reg = '0;

  result_word_t awaited_results [$];
  int           errors = 0;
  int           cycle_count = 0;
  bit           sender_idles = 1'b1;

  snapshot_array_store DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .index        (index),
    .write_value  (write_value),
    .snap_id      (snap_id),
    .done         (done),
    .read_value   (read_value),
    .taken_snap_id(taken_snap_id),
    .status       (status),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk = ~clk;

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // entry check; lengths above MAX_LENGTH clamp to it
  function automatic bit entry_in_range(input logic [7:0] idx);
    return ({1'b0, idx} < length_reg) && (int'(idx) < sas_pkg::MAX_LENGTH);
  endfunction

  // updates the mirrored state for one accepted word, returns its result
  function automatic result_word_t apply_word(input logic [1:0] c, input logic [7:0] i,
                                              input logic signed [31:0] v,
                                              input logic [3:0] s);
    result_word_t r;
    r = '{value: '0, snap: '0, st: sas_pkg::ST_OK};
    case (c)
      sas_pkg::CMD_SET: begin
        if (entry_in_range(i)) working_mirror[i] = v;
        else r.st = sas_pkg::ST_INVALID;
      end
      sas_pkg::CMD_SNAP: begin
        if (slots_used < sas_pkg::MAX_SNAPSHOTS) begin
          for (int k = 0; k < sas_pkg::MAX_LENGTH; k++)
            saved_mirror[slots_used[sas_pkg::SLOT_W-1:0]][k] = working_mirror[k];
          r.snap = slots_used[3:0];
          slots_used = slots_used + 1'b1;
        end else begin
          r.st = sas_pkg::ST_FULL;
        end
      end
      sas_pkg::CMD_GET: begin
        // slot must be fully taken and the entry inside the length
        if ((s < slots_used) && entry_in_range(i)) begin
          r.value = saved_mirror[s][i];
        end else begin
          r.value = -32'sd1;
          r.st    = sas_pkg::ST_INVALID;
        end
      end
      default: r.st = sas_pkg::ST_INVALID;
    endcase
    return r;
  endfunction

  // result checker: one strobe per word, no backpressure on this side
  always @(posedge clk) begin
    result_word_t exp_w;
    if (!rst && done) begin
      if (awaited_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result word: value %0d snap %0d status %0d",
                   read_value, taken_snap_id, status);
      end else begin
        exp_w = awaited_results.pop_front();
        if (read_value !== exp_w.value || taken_snap_id !== exp_w.snap ||
            status !== exp_w.st) begin
          errors++;
          if (errors <= 10)
            $display("result mismatch: exp value %0d snap %0d status %0d, got %0d %0d %0d",
                     exp_w.value, exp_w.snap, exp_w.st, read_value, taken_snap_id, status);
        end
      end
    end
  end

  // drive one command word at the falling edge, hold until accepted
  task automatic send_word(input logic [1:0] c, input logic [7:0] i,
                           input logic signed [31:0] v, input logic [3:0] s);
    int gap;
    gap = 0;
    if (sender_idles && $urandom_range(99) < 6) gap = $urandom_range(4, 1);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start       <= 1'b1;
    cmd         <= c;
    index       <= i;
    write_value <= v;
    snap_id     <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
    awaited_results.push_back(apply_word(c, i, v, s));
  endtask

  // stop sending and wait for every pending word, then a short tail
  task automatic settle(input int tail);
    @(negedge clk);
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  // APB write of the length register, only while idle
  task automatic write_length(input logic [sas_pkg::LEN_W-1:0] len);
    settle(4);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sas_pkg::REG_ARRAY_LENGTH, 2'b00};
    pwdata  <= 32'(len);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    length_reg = len;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // zero length, nothing taken, unknown command
  task automatic test_empty_store();
    send_word(sas_pkg::CMD_GET, 8'd0, 32'sd0, 4'd0);
    send_word(sas_pkg::CMD_SET, 8'd0, 32'sd77, 4'd0);
    send_word(CMD_UNUSED, 8'hFF, -32'sd1, 4'hF);
  endtask

  // value extremes, first snapshots, never-set entries, untaken slots
  task automatic test_extreme_values();
    write_length(9'd256);
    send_word(sas_pkg::CMD_SET, 8'd0, 32'sh7FFFFFFF, 4'd0);
    send_word(sas_pkg::CMD_SET, 8'd255, 32'sh80000000, 4'd0);
    send_word(sas_pkg::CMD_SET, 8'd1, -32'sd1, 4'd0);
    send_word(sas_pkg::CMD_SET, 8'd2, 32'sd0, 4'd0);
    send_word(sas_pkg::CMD_SNAP, 8'd0, 32'sd0, 4'd0);
    send_word(sas_pkg::CMD_GET, 8'd0, 32'sd0, 4'd0);
    send_word(sas_pkg::CMD_GET, 8'd255, 32'sd0, 4'd0);
    send_word(sas_pkg::CMD_GET, 8'd1, 32'sd0, 4'd0);
    send_word(sas_pkg::CMD_GET, 8'd3, 32'sd0, 4'd0);   // never set, reads zero
    send_word(sas_pkg::CMD_GET, 8'd0, 32'sd0, 4'd1);   // slot 1 not taken yet
    send_word(sas_pkg::CMD_SET, 8'd0, 32'sd5, 4'd0);
    send_word(sas_pkg::CMD_SNAP, 8'd0, 32'sd0, 4'd0);
    send_word(sas_pkg::CMD_GET, 8'd0, 32'sd0, 4'd0);   // old copy keeps its value
    send_word(sas_pkg::CMD_GET, 8'd0, 32'sd0, 4'd1);
  endtask

  // clamp above MAX_LENGTH and the one-entry length
  task automatic test_length_limits();
    write_length(9'd511);
    send_word(sas_pkg::CMD_GET, 8'd255, 32'sd0, 4'd1);
    write_length(9'd1);
    send_word(sas_pkg::CMD_GET, 8'd1, 32'sd0, 4'd1);
    send_word(sas_pkg::CMD_GET, 8'd0, 32'sd0, 4'd1);
    send_word(sas_pkg::CMD_SET, 8'd1, 32'sd9, 4'd0);
    send_word(sas_pkg::CMD_GET, 8'd0, 32'sd0, 4'hF);
  endtask

  // mostly well-formed sets and gets on taken slots, some noise
  task automatic test_random_traffic(input int words, input logic [sas_pkg::LEN_W-1:0] len,
                                     input bit idles);
    int         eff;
    int         r;
    logic [1:0] c;
    logic [7:0] i;
    logic [31:0] v;
    logic [3:0] s;
    write_length(len);
    sender_idles = idles;
    eff = (int'(len) > sas_pkg::MAX_LENGTH) ? sas_pkg::MAX_LENGTH : int'(len);
    repeat (words) begin
      r = $urandom_range(999);
      if (r < 7) c = sas_pkg::CMD_SNAP;
      else if (r < 37) c = CMD_UNUSED;
      else if (r < 450) c = sas_pkg::CMD_SET;
      else c = sas_pkg::CMD_GET;
      if (eff > 0 && $urandom_range(99) < 80) i = 8'($urandom_range(eff - 1, 0));
      else i = 8'($urandom);
      if (slots_used > 0 && $urandom_range(99) < 80)
        s = 4'($urandom_range(int'(slots_used) - 1, 0));
      else s = 4'($urandom);
      case ($urandom_range(19))
        0: v = 32'h7FFFFFFF;
        1: v = 32'h80000000;
        2: v = 32'hFFFFFFFF;
        default: v = $urandom;
      endcase
      send_word(c, i, v, s);
    end
    sender_idles = 1'b1;
  endtask

  // use the remaining slots, then snapshots are refused
  task automatic test_store_full();
    write_length(9'd256);
    while (slots_used < sas_pkg::MAX_SNAPSHOTS) begin
      send_word(sas_pkg::CMD_SET, 8'($urandom), 32'($urandom), 4'd0);
      send_word(sas_pkg::CMD_SNAP, 8'd0, 32'sd0, 4'd0);
    end
    send_word(sas_pkg::CMD_SET, 8'd7, 32'sd123, 4'd0);
    send_word(sas_pkg::CMD_SNAP, 8'd0, 32'sd0, 4'd0);
    send_word(sas_pkg::CMD_SNAP, 8'd0, 32'sd0, 4'd0);
    send_word(sas_pkg::CMD_GET, 8'd7, 32'sd0, 4'hF);   // last slot predates the set
    repeat (40)
      send_word(sas_pkg::CMD_GET, 8'($urandom), 32'sd0, 4'($urandom));
  endtask

  initial begin
    for (int k = 0; k < sas_pkg::MAX_LENGTH; k++) begin
      working_mirror[k] = '0;
      for (int n = 0; n < sas_pkg::MAX_SNAPSHOTS; n++) saved_mirror[n][k] = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_store();
    test_extreme_values();
    test_length_limits();
    test_random_traffic(300, 9'd256, 1'b1);
    test_random_traffic(300, 9'd1, 1'b1);
    test_random_traffic(300, 9'd511, 1'b0);   // back-to-back stretch
    test_random_traffic(250, 9'd0, 1'b1);
    test_random_traffic(300, 9'($urandom_range(255, 2)), 1'b1);
    test_random_traffic(250, 9'd256, 1'b1);
    test_store_full();

    settle(sas_pkg::MAX_LENGTH + 8);
    if (errors == 0 && awaited_results.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
